>>> rtl/mi4_pkg.sv
// Shared types and constants for the 4x4 matrix inverse block.
package mi4_pkg;

  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 4;
  localparam int NUM_ELEM      = 16;
  localparam int CW            = 97;
  localparam int DW            = 130;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] THRESH_RESET = 32'd43;

  localparam logic [2:0] MA_E   = 3'd0;
  localparam logic [2:0] MA_PLO = 3'd1;
  localparam logic [2:0] MA_PHI = 3'd2;
  localparam logic [2:0] MA_CL0 = 3'd3;
  localparam logic [2:0] MA_CL1 = 3'd4;
  localparam logic [2:0] MA_CL2 = 3'd5;

  localparam logic MB_E   = 1'b0;
  localparam logic MB_MAT = 1'b1;

  typedef struct packed {
    logic              mat_we;
    logic [ADDR_W-1:0] mat_waddr;
    logic              mat_re;
    logic [ADDR_W-1:0] mat_raddr;
    logic              cof_re;
    logic [ADDR_W-1:0] cof_raddr;
    logic              cof_we;
    logic [ADDR_W-1:0] cof_waddr;
    logic              e_load;
    logic              mul_en;
    logic [2:0]        mul_a_sel;
    logic              mul_b_sel;
    logic              p_load;
    logic              acc_clr;
    logic              acc_add;
    logic              acc_neg;
    logic [1:0]        acc_shift;
    logic              det_load;
    logic              div_load;
    logic              div_step;
    logic              out_valid;
    logic              out_zero;
    logic              out_last;
  } mi4_cmd_t;

  typedef struct packed {
    logic sing;
  } mi4_sts_t;

endpackage

>>> rtl/matrix4x4_inverse_top.sv
// Top level of the 4x4 fixed-point matrix inverse block.
// Elements load one per cycle while busy is low, column-major. The sixteenth starts the
// computation: the sixteen cofactors are formed on the shared 33x32 multiplier, then the
// determinant, then the singular check. Each result of a non-singular matrix then comes
// from the 33-step restoring divider; a singular matrix gives one zero result per cycle. Each
// result transaction shows for one cycle on result_strobe and cannot be held off; busy
// falls as the last result leaves.
module matrix4x4_inverse_top #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] inverse_value,
  output logic               singular,
  output logic               saturated,
  output logic               last_of_matrix,
  output logic               result_strobe
);

  mi4_pkg::mi4_cmd_t cmd;
  mi4_pkg::mi4_sts_t sts;

  mi4_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mi4_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .element_value  (element_value),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .inverse_value  (inverse_value),
    .singular       (singular),
    .saturated      (saturated),
    .last_of_matrix (last_of_matrix),
    .result_strobe  (result_strobe)
  );

endmodule

>>> rtl/mi4_controller.sv
// Sequencer for loading, cofactors, determinant, division and result output.
module mi4_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mi4_pkg::mi4_sts_t  sts,
  output mi4_pkg::mi4_cmd_t  cmd
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_COF  = 4'd1;
  localparam logic [3:0] S_COFW = 4'd2;
  localparam logic [3:0] S_DET  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_KRD  = 4'd5;
  localparam logic [3:0] S_DLD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DOUT = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] load_count, load_count_next;
  logic [3:0] kk, kk_next;
  logic [2:0] term, term_next;
  logic [2:0] ph, ph_next;
  logic [5:0] cnt, cnt_next;

  function automatic logic [3:0] elem_addr(input logic [1:0] dr, input logic [1:0] dc,
                                           input logic [2:0] t, input logic [1:0] f);
    logic [5:0] perm;
    logic [1:0] ri;
    logic [1:0] col;
    logic [1:0] row;
    unique case (t)
      3'd0:    perm = {2'd2, 2'd1, 2'd0};
      3'd1:    perm = {2'd1, 2'd2, 2'd0};
      3'd2:    perm = {2'd2, 2'd0, 2'd1};
      3'd3:    perm = {2'd0, 2'd2, 2'd1};
      3'd4:    perm = {2'd1, 2'd0, 2'd2};
      default: perm = {2'd0, 2'd1, 2'd2};
    endcase
    unique case (f)
      2'd0:    ri = perm[1:0];
      2'd1:    ri = perm[3:2];
      default: ri = perm[5:4];
    endcase
    col = (f >= dc) ? 2'(f + 2'd1) : f;
    row = (ri >= dr) ? 2'(ri + 2'd1) : ri;
    return {col, row};
  endfunction

  function automatic logic term_neg(input logic [2:0] t);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

  always_comb begin
    cmd              = '0;
    state_next       = state;
    load_count_next  = load_count;
    kk_next          = kk;
    term_next        = term;
    ph_next          = ph;
    cnt_next         = cnt;
    unique case (state)
      S_LOAD: begin
        if (start) begin
          cmd.mat_we      = 1'b1;
          cmd.mat_waddr   = load_count;
          load_count_next = 4'(load_count + 4'd1);
          if (load_count == 4'd15) begin
            cmd.acc_clr = 1'b1;
            kk_next     = '0;
            term_next   = '0;
            ph_next     = '0;
            state_next  = S_COF;
          end
        end
      end
      S_COF: begin
        cmd.mat_raddr = elem_addr(kk[3:2], kk[1:0], term, ph[1:0]);
        cmd.acc_neg   = term_neg(term) ^ kk[2] ^ kk[0];
        unique case (ph)
          3'd0: cmd.mat_re = 1'b1;
          3'd1: begin
            cmd.mat_re = 1'b1;
            cmd.e_load = 1'b1;
          end
          3'd2: begin
            cmd.mat_re    = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_E;
            cmd.mul_b_sel = mi4_pkg::MB_MAT;
          end
          3'd3: begin
            cmd.p_load = 1'b1;
            cmd.e_load = 1'b1;
          end
          3'd4: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_PLO;
            cmd.mul_b_sel = mi4_pkg::MB_E;
          end
          3'd5: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_PHI;
            cmd.mul_b_sel = mi4_pkg::MB_E;
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 2'd0;
          end
          default: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 2'd1;
          end
        endcase
        if (ph == 3'd6) begin
          ph_next = '0;
          if (term == 3'd5) begin
            term_next  = '0;
            state_next = S_COFW;
          end else begin
            term_next = 3'(term + 3'd1);
          end
        end else begin
          ph_next = 3'(ph + 3'd1);
        end
      end
      S_COFW: begin
        cmd.cof_we    = 1'b1;
        cmd.cof_waddr = kk;
        cmd.acc_clr   = 1'b1;
        kk_next       = 4'(kk + 4'd1);
        state_next    = (kk == 4'd15) ? S_DET : S_COF;
      end
      S_DET: begin
        cmd.mat_raddr = {2'b00, kk[1:0]};
        cmd.cof_raddr = {kk[1:0], 2'b00};
        cmd.mul_b_sel = mi4_pkg::MB_MAT;
        unique case (ph)
          3'd0: begin
            cmd.mat_re = 1'b1;
            cmd.cof_re = 1'b1;
          end
          3'd1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_CL0;
          end
          3'd2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_CL1;
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 2'd0;
          end
          3'd3: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_a_sel = mi4_pkg::MA_CL2;
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 2'd1;
          end
          default: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 2'd2;
          end
        endcase
        if (ph == 3'd4) begin
          ph_next = '0;
          if (kk == 4'd3) begin
            kk_next    = '0;
            state_next = S_CHK;
          end else begin
            kk_next = 4'(kk + 4'd1);
          end
        end else begin
          ph_next = 3'(ph + 3'd1);
        end
      end
      S_CHK: begin
        cmd.det_load = 1'b1;
        state_next   = S_KRD;
      end
      S_KRD: begin
        if (sts.sing) begin
          cmd.out_valid = 1'b1;
          cmd.out_zero  = 1'b1;
          cmd.out_last  = (kk == 4'd15);
          kk_next       = 4'(kk + 4'd1);
          if (kk == 4'd15) state_next = S_LOAD;
        end else begin
          cmd.cof_re    = 1'b1;
          cmd.cof_raddr = kk;
          state_next    = S_DLD;
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = 6'(cnt + 6'd1);
        if (cnt == 6'd32) state_next = S_DOUT;
      end
      S_DOUT: begin
        cmd.out_valid = 1'b1;
        cmd.out_last  = (kk == 4'd15);
        kk_next       = 4'(kk + 4'd1);
        state_next    = (kk == 4'd15) ? S_LOAD : S_KRD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      kk         <= '0;
      term       <= '0;
      ph         <= '0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      kk         <= kk_next;
      term       <= term_next;
      ph         <= ph_next;
      cnt        <= cnt_next;
    end
  end

  assign busy = (state != S_LOAD);

endmodule

>>> rtl/mi4_datapath.sv
// Storage, shared multiplier, accumulator and restoring divider of the inverse block.
module mi4_datapath #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mi4_pkg::mi4_cmd_t         cmd,
  output mi4_pkg::mi4_sts_t         sts,
  input  logic signed [31:0]        element_value,
  input  logic                      cfg_write,
  input  logic [31:0]               cfg_data,
  output logic signed [31:0]        inverse_value,
  output logic                      singular,
  output logic                      saturated,
  output logic                      last_of_matrix,
  output logic                      result_strobe
);

  localparam int CW  = mi4_pkg::CW;
  localparam int DW  = mi4_pkg::DW;
  localparam int QSH = 2 * FRAC_BITS;
  localparam int LSH = 4 * FRAC_BITS - 32;
  localparam int XW  = (CW + QSH > DW + 33) ? CW + QSH : DW + 33;

  logic [31:0]        mat_mem [mi4_pkg::NUM_ELEM];
  logic [31:0]        mat_q;
  logic [CW-1:0]      cof_mem [mi4_pkg::NUM_ELEM];
  logic [CW-1:0]      cof_q;
  logic [31:0]        e_reg;
  logic [63:0]        p_reg;
  logic signed [64:0] prod;
  logic [DW-1:0]      acc;
  logic [DW-1:0]      mag;
  logic               det_neg;
  logic               sing;
  logic [31:0]        threshold;
  logic [XW-1:0]      rem;
  logic [XW-1:0]      dsh;
  logic [32:0]        quo;
  logic               qneg;

  logic signed [32:0] op_a;
  logic signed [31:0] op_b;
  logic [DW-1:0]      ext_sh;
  logic [DW-1:0]      term_v;
  logic [DW-1:0]      acc_abs;
  logic [DW-1:0]      limit;
  logic [CW-1:0]      cof_abs;
  logic               ge;
  logic               sat_c;
  logic [31:0]        val_c;

  always_comb begin
    unique case (cmd.mul_a_sel)
      mi4_pkg::MA_E:   op_a = {e_reg[31], e_reg};
      mi4_pkg::MA_PLO: op_a = {1'b0, p_reg[31:0]};
      mi4_pkg::MA_PHI: op_a = {p_reg[63], p_reg[63:32]};
      mi4_pkg::MA_CL0: op_a = {1'b0, cof_q[31:0]};
      mi4_pkg::MA_CL1: op_a = {1'b0, cof_q[63:32]};
      mi4_pkg::MA_CL2: op_a = cof_q[96:64];
      default:         op_a = '0;
    endcase
    op_b = (cmd.mul_b_sel == mi4_pkg::MB_MAT) ? mat_q : e_reg;
  end

  assign ext_sh  = {{(DW-65){prod[64]}}, prod} << {cmd.acc_shift, 5'b00000};
  assign term_v  = cmd.acc_neg ? (~ext_sh + 1'b1) : ext_sh;
  assign acc_abs = acc[DW-1] ? (~acc + 1'b1) : acc;
  assign limit   = {{(DW-32){1'b0}}, threshold} << LSH;
  assign cof_abs = cof_q[CW-1] ? (~cof_q + 1'b1) : cof_q;
  assign ge      = (rem >= dsh);

  always_comb begin
    if (qneg) begin
      sat_c = quo[32] | (quo[31] & (|quo[30:0]));
      val_c = sat_c ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
    end else begin
      sat_c = quo[32] | quo[31];
      val_c = sat_c ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_we) mat_mem[cmd.mat_waddr] <= element_value;
    if (cmd.mat_re) mat_q <= mat_mem[cmd.mat_raddr];
    if (cmd.cof_we) cof_mem[cmd.cof_waddr] <= acc[CW-1:0];
    if (cmd.cof_re) cof_q <= cof_mem[cmd.cof_raddr];
    if (cmd.e_load) e_reg <= mat_q;
    if (cmd.mul_en) prod <= op_a * op_b;
    if (cmd.p_load) p_reg <= prod[63:0];
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + term_v;
    end
    if (cmd.det_load) begin
      mag     <= acc_abs;
      det_neg <= acc[DW-1];
    end
    if (cmd.div_load) begin
      rem  <= {{(XW-CW){1'b0}}, cof_abs} << QSH;
      dsh  <= {{(XW-DW){1'b0}}, mag} << 32;
      quo  <= '0;
      qneg <= cof_q[CW-1] ^ det_neg;
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[31:0], ge};
    end
    if (cmd.out_valid) begin
      inverse_value  <= cmd.out_zero ? 32'sd0 : val_c;
      saturated      <= cmd.out_zero ? 1'b0 : sat_c;
      singular       <= sing;
      last_of_matrix <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= mi4_pkg::THRESH_RESET;
      sing          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_write) threshold <= cfg_data;
      if (cmd.det_load) sing <= (acc == '0) || (acc_abs < limit);
      result_strobe <= cmd.out_valid;
    end
  end

  assign sts.sing = sing;

endmodule

>>> tb/mi4_inverse_checker.sv
// Checker for the 4x4 matrix inverse block: predicts the inverse and compares each result.
module mi4_inverse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] element_value,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] inverse_value,
  input  logic               singular,
  input  logic               saturated,
  input  logic               last_of_matrix,
  input  logic               result_strobe,
  input  logic               end_of_test,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] value;
    logic               sing;
    logic               sat;
    logic               last;
  } inv_elem_t;

  inv_elem_t          pending_inverse[$];
  logic signed [31:0] mat_elems[16];
  int                 elems_loaded;
  logic [31:0]        sing_threshold;

  function automatic wide_t cofactor_of(int drop_row, int drop_col);
    wide_t m[3][3];
    wide_t d;
    int    ci;
    int    ri;
    ci = 0;
    for (int c = 0; c < 4; c++) begin
      if (c != drop_col) begin
        ri = 0;
        for (int r = 0; r < 4; r++) begin
          if (r != drop_row) begin
            m[ci][ri] = wide_t'(mat_elems[c*4 + r]);
            ri++;
          end
        end
        ci++;
      end
    end
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((drop_row + drop_col) % 2 == 1) ? -d : d;
  endfunction

  task automatic predict_inverse();
    wide_t       det;
    wide_t       a;
    logic [255:0] mag;
    logic [255:0] q;
    logic [255:0] abs_a;
    logic        sing;
    logic        neg;
    inv_elem_t   e;
    det = '0;
    for (int k = 0; k < 4; k++) det += wide_t'(mat_elems[k]) * cofactor_of(k, 0);
    mag  = det < 0 ? -det : det;
    sing = (det == 0) || (mag < ({224'd0, sing_threshold} << 32));
    for (int k = 0; k < 16; k++) begin
      e.value = '0;
      e.sat   = 1'b0;
      if (!sing) begin
        a     = cofactor_of(k / 4, k % 4);
        neg   = (a < 0) != (det < 0);
        abs_a = a < 0 ? -a : a;
        q     = (abs_a << 32) / mag;
        if (neg) begin
          if (q > 256'h8000_0000) begin
            e.value = 32'sh8000_0000;
            e.sat   = 1'b1;
          end else begin
            e.value = -q[31:0];
          end
        end else begin
          if (q >= 256'h8000_0000) begin
            e.value = 32'sh7FFF_FFFF;
            e.sat   = 1'b1;
          end else begin
            e.value = q[31:0];
          end
        end
      end
      e.sing = sing;
      e.last = (k == 15);
      pending_inverse.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    inv_elem_t e;
    if (rst) begin
      elems_loaded   = 0;
      sing_threshold = 32'd43;
      pending_inverse.delete();
    end else begin
      if (result_strobe) begin
        if (pending_inverse.size() == 0) begin
          $display("%0t: unexpected result transaction: value %h singular %b saturated %b last %b",
                   $time, inverse_value, singular, saturated, last_of_matrix);
          fail_count++;
        end else begin
          e = pending_inverse.pop_front();
          if (e.value !== inverse_value || e.sing !== singular || e.sat !== saturated ||
              e.last !== last_of_matrix) begin
            $display("%0t: mismatch: expected value %h singular %b saturated %b last %b",
                     $time, e.value, e.sing, e.sat, e.last);
            $display("%0t:           actual value %h singular %b saturated %b last %b",
                     $time, inverse_value, singular, saturated, last_of_matrix);
            fail_count++;
          end
        end
      end
      if (cfg_write) sing_threshold = cfg_data;
      if (start && !busy) begin
        mat_elems[elems_loaded] = element_value;
        elems_loaded++;
        if (elems_loaded == 16) begin
          elems_loaded = 0;
          predict_inverse();
        end
      end
    end
  end

  initial fail_count = 0;

  always @(posedge end_of_test) begin
    if (pending_inverse.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_inverse.size());
      fail_count++;
    end
  end
endmodule

>>> tb/tb_matrix4x4_inverse_top.sv
// Testbench top for the 4x4 matrix inverse block: stimulus, configuration and verdict.
module tb_matrix4x4_inverse_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] element_value;
  logic               cfg_write;
  logic [31:0]        cfg_data;
  logic signed [31:0] inverse_value;
  logic               singular;
  logic               saturated;
  logic               last_of_matrix;
  logic               result_strobe;
  logic               end_of_test;
  int                 fail_count;
  int                 cycles;
  int                 idle_pct;
  logic signed [31:0] next_matrix[16];

  matrix4x4_inverse_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .element_value(element_value),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .inverse_value(inverse_value),
    .singular(singular), .saturated(saturated), .last_of_matrix(last_of_matrix),
    .result_strobe(result_strobe)
  );

  mi4_inverse_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .element_value(element_value),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .inverse_value(inverse_value),
    .singular(singular), .saturated(saturated), .last_of_matrix(last_of_matrix),
    .result_strobe(result_strobe), .end_of_test(end_of_test), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Hold start until the block takes the transaction.
  task automatic send_element(logic signed [31:0] v);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    element_value <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic send_matrix();
    for (int i = 0; i < 16; i++) send_element(next_matrix[i]);
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic make_diag(logic signed [31:0] d0, logic signed [31:0] d1,
                           logic signed [31:0] d2, logic signed [31:0] d3);
    for (int i = 0; i < 16; i++) next_matrix[i] = '0;
    next_matrix[0]  = d0;
    next_matrix[5]  = d1;
    next_matrix[10] = d2;
    next_matrix[15] = d3;
  endtask

  task automatic make_random_matrix();
    int mode;
    mode = $urandom_range(0, 4);
    for (int i = 0; i < 16; i++) begin
      case (mode)
        0: next_matrix[i] = $urandom;
        1: next_matrix[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        2: next_matrix[i] = $signed($urandom_range(0, 32'h0000_0200)) - 32'sh0000_0100;
        default: next_matrix[i] = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
    end
    if (mode == 3) begin
      for (int i = 0; i < 4; i++) next_matrix[i] += 32'sh0040_0000;
      next_matrix[5]  += 32'sh0040_0000;
      next_matrix[10] += 32'sh0040_0000;
      next_matrix[15] += 32'sh0040_0000;
    end
    if (mode == 4 && $urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 4; i++) next_matrix[12 + i] = next_matrix[i];
    end
  endtask

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd43;
      3: return $urandom_range(0, 4096);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    element_value = '0;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    end_of_test   = 1'b0;
    cycles        = 0;
    idle_pct      = 11;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    write_threshold(32'd0);
    make_diag(32'sd1, -32'sd1, 32'sd1, 32'sd1);
    send_matrix();
    make_diag(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000);
    send_matrix();
    for (int i = 0; i < 16; i++) next_matrix[i] = '0;
    send_matrix();
    wait_idle();
    write_threshold(32'hFFFF_FFFF);
    make_diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_matrix();
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 76 : 0;
      for (int n = 0; n < 7; n++) begin
        if (n % 3 == 0) begin
          wait_idle();
          write_threshold(pick_threshold());
        end
        make_random_matrix();
        send_matrix();
      end
      wait_idle();
    end

    repeat (50) @(negedge clk);
    end_of_test = 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/mi4_pkg.sv
rtl/mi4_controller.sv
rtl/mi4_datapath.sv
rtl/matrix4x4_inverse_top.sv
tb/mi4_inverse_checker.sv
tb/tb_matrix4x4_inverse_top.sv
